[sv/rwtd_pkg.sv]
package rwtd_pkg;

  // Sizing
  localparam int unsigned RD_DEPTH         = 32;
  localparam int unsigned WR_DEPTH         = 16;
  localparam int unsigned TASK_ID_BITS     = 8;
  localparam int unsigned ACTIVE_READ_BITS = 16;

  // Fixed field widths of the request and result
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned ID_FIELD_W = 8;
  localparam int unsigned STATUS_W   = 2;

  // Derived widths
  localparam int unsigned RP_W = $clog2(RD_DEPTH);
  localparam int unsigned WP_W = $clog2(WR_DEPTH);
  localparam int unsigned WC_W = $clog2(WR_DEPTH + 2);
  localparam int unsigned QR_W = $clog2(RD_DEPTH + 1);
  localparam int unsigned AR_W = ACTIVE_READ_BITS;

  // Queued reads are bounded by the queue depth and by the active read counter
  localparam longint unsigned ACTIVE_MAX = (64'd1 << ACTIVE_READ_BITS) - 64'd1;
  localparam int unsigned RD_LIMIT =
    (ACTIVE_MAX < 64'(RD_DEPTH)) ? int'(ACTIVE_MAX) : RD_DEPTH;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_RD_ENQ  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WR_ENQ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RD_DONE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_WR_DONE = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_REJECT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOTRUN = 2'd2;

  // Task kinds
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_WRITE = 1'b1;

  typedef struct packed {
    logic [CMD_W-1:0]      cmd;
    logic [ID_FIELD_W-1:0] task_id;
  } in_req_t;

  typedef struct packed {
    logic                  started;
    logic                  started_kind;
    logic [ID_FIELD_W-1:0] started_id;
    logic [STATUS_W-1:0]   status;
    logic                  last;
  } out_res_t;

  // What an executed request needs next
  typedef enum logic [1:0] {
    ACT_EMIT,
    ACT_POP_WRITE,
    ACT_RELEASE
  } act_e;

  // Controller to datapath
  typedef struct packed {
    logic latch;
    logic exec;
    logic wpop_emit;
    logic rel_step;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    act_e act;
    logic rel_last;
  } dp_stat_t;

endpackage

[sv/rwtd_ram.sv]
module rwtd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/rwtd_ctrl.sv]
module rwtd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rwtd_pkg::dp_stat_t stat,
  output rwtd_pkg::ctl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WPOP,
    S_REL
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        case (stat.act)
          rwtd_pkg::ACT_POP_WRITE: state_nxt = S_WPOP;
          rwtd_pkg::ACT_RELEASE:   state_nxt = S_REL;
          default:                 state_nxt = S_IDLE;
        endcase
      end
      S_WPOP: begin
        cmd.wpop_emit = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_REL: begin
        cmd.rel_step = 1'b1;
        if (stat.rel_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  assign busy = busy_r;

endmodule

[sv/rwtd_dp.sv]
module rwtd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  rwtd_pkg::in_req_t  in_req,
  input  rwtd_pkg::ctl_cmd_t cmd,
  output rwtd_pkg::dp_stat_t stat,
  output logic               out_valid,
  output rwtd_pkg::out_res_t out_res
);

  localparam int unsigned RP_W = rwtd_pkg::RP_W;
  localparam int unsigned WP_W = rwtd_pkg::WP_W;
  localparam int unsigned WC_W = rwtd_pkg::WC_W;
  localparam int unsigned QR_W = rwtd_pkg::QR_W;
  localparam int unsigned AR_W = rwtd_pkg::AR_W;
  localparam int unsigned TW   = rwtd_pkg::TASK_ID_BITS;

  rwtd_pkg::in_req_t  req_r;
  rwtd_pkg::out_res_t out_r, out_nxt, res;
  logic               out_valid_r, out_valid_nxt;

  logic [WC_W-1:0] wc_r, wc_nxt;
  logic [AR_W-1:0] ar_r, ar_nxt;
  logic [QR_W-1:0] qr_r, qr_nxt;
  logic [QR_W-1:0] rel_cnt_r;
  logic [RP_W-1:0] rh_r, rt_r;
  logic [WP_W-1:0] wh_r, wt_r;

  logic [WC_W-1:0] wfifo_cnt;
  logic            rd_push, wr_push, wr_pop, rel;
  logic            rel_last, rh_adv;
  rwtd_pkg::act_e  act;
  logic [TW-1:0]   rd_q, wr_q;

  // Wait queues
  rwtd_ram #(.WIDTH(TW), .DEPTH(rwtd_pkg::RD_DEPTH)) u_rd_ram (
    .clk   (clk),
    .we    (cmd.exec && rd_push),
    .waddr (rt_r),
    .wdata (TW'(req_r.task_id)),
    .raddr (rh_r),
    .rdata (rd_q)
  );

  rwtd_ram #(.WIDTH(TW), .DEPTH(rwtd_pkg::WR_DEPTH)) u_wr_ram (
    .clk   (clk),
    .we    (cmd.exec && wr_push),
    .waddr (wt_r),
    .wdata (TW'(req_r.task_id)),
    .raddr (wh_r),
    .rdata (wr_q)
  );

  // Entries in the write queue: one fewer when a write is running
  assign wfifo_cnt = (wc_r != '0 && ar_r == '0) ? wc_r - WC_W'(1) : wc_r;
  assign rel_last  = (rel_cnt_r == QR_W'(1));

  // Request decision
  always_comb begin
    act          = rwtd_pkg::ACT_EMIT;
    res          = '0;
    res.last     = 1'b1;
    res.status   = rwtd_pkg::ST_OK;
    wc_nxt       = wc_r;
    ar_nxt       = ar_r;
    qr_nxt       = qr_r;
    rd_push      = 1'b0;
    wr_push      = 1'b0;
    wr_pop       = 1'b0;
    rel          = 1'b0;
    case (req_r.cmd)
      rwtd_pkg::CMD_RD_ENQ: begin
        if (wc_r != '0) begin
          if (qr_r >= QR_W'(rwtd_pkg::RD_LIMIT)) begin
            res.status = rwtd_pkg::ST_REJECT;
          end else begin
            rd_push = 1'b1;
            qr_nxt  = qr_r + QR_W'(1);
          end
        end else if (ar_r == '1) begin
          res.status = rwtd_pkg::ST_REJECT;
        end else begin
          ar_nxt           = ar_r + AR_W'(1);
          res.started      = 1'b1;
          res.started_kind = rwtd_pkg::KIND_READ;
          res.started_id   = rwtd_pkg::ID_FIELD_W'(TW'(req_r.task_id));
        end
      end
      rwtd_pkg::CMD_WR_ENQ: begin
        if (wc_r == '0 && ar_r == '0) begin
          wc_nxt           = WC_W'(1);
          res.started      = 1'b1;
          res.started_kind = rwtd_pkg::KIND_WRITE;
          res.started_id   = rwtd_pkg::ID_FIELD_W'(TW'(req_r.task_id));
        end else if (wfifo_cnt >= WC_W'(rwtd_pkg::WR_DEPTH)) begin
          res.status = rwtd_pkg::ST_REJECT;
        end else begin
          wr_push = 1'b1;
          wc_nxt  = wc_r + WC_W'(1);
        end
      end
      rwtd_pkg::CMD_RD_DONE: begin
        if (ar_r == '0) begin
          res.status = rwtd_pkg::ST_NOTRUN;
        end else begin
          ar_nxt = ar_r - AR_W'(1);
          if (ar_r == AR_W'(1) && wc_r != '0) begin
            wr_pop = 1'b1;
            act    = rwtd_pkg::ACT_POP_WRITE;
          end
        end
      end
      rwtd_pkg::CMD_WR_DONE: begin
        if (wc_r == '0 || ar_r != '0) begin
          res.status = rwtd_pkg::ST_NOTRUN;
        end else begin
          wc_nxt = wc_r - WC_W'(1);
          if (wc_r > WC_W'(1)) begin
            wr_pop = 1'b1;
            act    = rwtd_pkg::ACT_POP_WRITE;
          end else if (qr_r != '0) begin
            // last write gone: every waiting read starts
            rel    = 1'b1;
            ar_nxt = AR_W'(qr_r);
            qr_nxt = '0;
            act    = rwtd_pkg::ACT_RELEASE;
          end
        end
      end
      default: res.status = rwtd_pkg::ST_NOTRUN;
    endcase
  end

  assign stat.act      = act;
  assign stat.rel_last = rel_last;

  // Read head moves on the first release pop and on every release step but the last
  assign rh_adv = (cmd.exec && rel) || (cmd.rel_step && !rel_last);

  // Result register
  always_comb begin
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    if (cmd.exec && act == rwtd_pkg::ACT_EMIT) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (cmd.wpop_emit) begin
      out_valid_nxt        = 1'b1;
      out_nxt              = '0;
      out_nxt.started      = 1'b1;
      out_nxt.started_kind = rwtd_pkg::KIND_WRITE;
      out_nxt.started_id   = rwtd_pkg::ID_FIELD_W'(wr_q);
      out_nxt.status       = rwtd_pkg::ST_OK;
      out_nxt.last         = 1'b1;
    end else if (cmd.rel_step) begin
      out_valid_nxt        = 1'b1;
      out_nxt              = '0;
      out_nxt.started      = 1'b1;
      out_nxt.started_kind = rwtd_pkg::KIND_READ;
      out_nxt.started_id   = rwtd_pkg::ID_FIELD_W'(rd_q);
      out_nxt.status       = rwtd_pkg::ST_OK;
      out_nxt.last         = rel_last;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      req_r <= in_req;
    end
    out_r <= out_nxt;
  end

  // Counters and queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      ar_r        <= '0;
      qr_r        <= '0;
      rel_cnt_r   <= '0;
      rh_r        <= '0;
      rt_r        <= '0;
      wh_r        <= '0;
      wt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.exec) begin
        wc_r <= wc_nxt;
        ar_r <= ar_nxt;
        qr_r <= qr_nxt;
        if (rel) begin
          rel_cnt_r <= qr_r;
        end
        if (rd_push) begin
          rt_r <= (rt_r == RP_W'(rwtd_pkg::RD_DEPTH - 1)) ? '0 : rt_r + RP_W'(1);
        end
        if (wr_push) begin
          wt_r <= (wt_r == WP_W'(rwtd_pkg::WR_DEPTH - 1)) ? '0 : wt_r + WP_W'(1);
        end
        if (wr_pop) begin
          wh_r <= (wh_r == WP_W'(rwtd_pkg::WR_DEPTH - 1)) ? '0 : wh_r + WP_W'(1);
        end
      end
      if (cmd.rel_step) begin
        rel_cnt_r <= rel_cnt_r - QR_W'(1);
      end
      if (rh_adv) begin
        rh_r <= (rh_r == RP_W'(rwtd_pkg::RD_DEPTH - 1)) ? '0 : rh_r + RP_W'(1);
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_r;

endmodule

[sv/readers_writer_task_dispatcher_unit.sv]
// A result is strobed after the request is latched and then executed; a done event that
// starts a queued write passes through the write-pop state first. Releasing N queued reads
// strobes N results back to back from the release state, which follows the execute state.
// The block takes no new request until it is done with the last one; busy stays high until
// the final result is loaded.
// Synchronous active-low reset clears counters and queue pointers; results cannot stall.
module readers_writer_task_dispatcher_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  rwtd_pkg::in_req_t  in_req,
  output logic               out_valid,
  output rwtd_pkg::out_res_t out_res
);

  rwtd_pkg::ctl_cmd_t ctl_cmd;
  rwtd_pkg::dp_stat_t dp_stat;

  rwtd_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (dp_stat),
    .cmd   (ctl_cmd)
  );

  rwtd_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

endmodule

[sv/rwtd_checker.sv]
module rwtd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input rwtd_pkg::out_res_t out_res
);

  // A taken request keeps the block busy
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("busy low right after a request was taken");

  // Status-only results are always the single, final result of a request
  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.started) |-> out_res.last)
    else $error("status result without last mark");

  // A failing status never starts a task
  a_fail_no_start: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.status != rwtd_pkg::ST_OK) |-> !out_res.started)
    else $error("task started on a failing status");

  // Released reads come out back to back
  a_release_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_res.last) |=> out_valid)
    else $error("gap inside a read release burst");

  // The final result frees the block for the next request
  a_idle_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_res.last) |-> !busy)
    else $error("still busy while final result is shown");

endmodule

bind readers_writer_task_dispatcher_unit rwtd_checker u_rwtd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_res   (out_res)
);

[test/tb_readers_writer_task_dispatcher_unit.sv]
// Tracks the lock state the block should hold and the results it owes.
class dispatch_tracker;
  int unsigned                     writes;        // writes present, running or waiting
  int unsigned                     active_reads;  // reads currently running
  logic [rwtd_pkg::ID_FIELD_W-1:0] read_ids[$];   // reads parked behind writes
  logic [rwtd_pkg::ID_FIELD_W-1:0] write_ids[$];  // writes waiting for their turn
  rwtd_pkg::out_res_t              expected_results[$];
  int unsigned                     mismatches;

  function void add_result(logic started, logic kind,
                           logic [rwtd_pkg::ID_FIELD_W-1:0] id,
                           logic [rwtd_pkg::STATUS_W-1:0] status, logic last);
    rwtd_pkg::out_res_t r;
    r.started      = started;
    r.started_kind = kind;
    r.started_id   = id;
    r.status       = status;
    r.last         = last;
    expected_results.push_back(r);
  endfunction

  function void add_status(logic [rwtd_pkg::STATUS_W-1:0] status);
    add_result(1'b0, rwtd_pkg::KIND_READ, '0, status, 1'b1);
  endfunction

  // Apply one accepted request and queue the results it should cause
  function void note_request(rwtd_pkg::in_req_t req);
    logic [rwtd_pkg::ID_FIELD_W-1:0] id;
    int unsigned                     n;
    int unsigned                     i;
    id = req.task_id &
         rwtd_pkg::ID_FIELD_W'((1 << rwtd_pkg::TASK_ID_BITS) - 1);
    case (req.cmd)
      rwtd_pkg::CMD_RD_ENQ: begin
        if (writes > 0) begin
          // writer preference: park the read
          if (read_ids.size() >= rwtd_pkg::RD_LIMIT) begin
            add_status(rwtd_pkg::ST_REJECT);
          end else begin
            read_ids.push_back(id);
            add_status(rwtd_pkg::ST_OK);
          end
        end else if (active_reads >= rwtd_pkg::ACTIVE_MAX) begin
          add_status(rwtd_pkg::ST_REJECT);
        end else begin
          active_reads++;
          add_result(1'b1, rwtd_pkg::KIND_READ, id, rwtd_pkg::ST_OK, 1'b1);
        end
      end
      rwtd_pkg::CMD_WR_ENQ: begin
        if (writes == 0 && active_reads == 0) begin
          writes = 1;
          add_result(1'b1, rwtd_pkg::KIND_WRITE, id, rwtd_pkg::ST_OK, 1'b1);
        end else if (write_ids.size() >= rwtd_pkg::WR_DEPTH) begin
          add_status(rwtd_pkg::ST_REJECT);
        end else begin
          write_ids.push_back(id);
          writes++;
          add_status(rwtd_pkg::ST_OK);
        end
      end
      rwtd_pkg::CMD_RD_DONE: begin
        if (active_reads == 0) begin
          add_status(rwtd_pkg::ST_NOTRUN);
        end else begin
          active_reads--;
          if (active_reads == 0 && writes > 0)
            add_result(1'b1, rwtd_pkg::KIND_WRITE, write_ids.pop_front(),
                       rwtd_pkg::ST_OK, 1'b1);
          else
            add_status(rwtd_pkg::ST_OK);
        end
      end
      default: begin
        if (writes == 0 || active_reads > 0) begin
          add_status(rwtd_pkg::ST_NOTRUN);
        end else begin
          writes--;
          if (writes > 0) begin
            add_result(1'b1, rwtd_pkg::KIND_WRITE, write_ids.pop_front(),
                       rwtd_pkg::ST_OK, 1'b1);
          end else if (read_ids.size() == 0) begin
            add_status(rwtd_pkg::ST_OK);
          end else begin
            // last write gone: release every parked read at once
            n = read_ids.size();
            active_reads = n;
            for (i = 0; i < n; i++)
              add_result(1'b1, rwtd_pkg::KIND_READ, read_ids.pop_front(),
                         rwtd_pkg::ST_OK, i == n - 1);
          end
        end
      end
    endcase
  endfunction

  function void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Compare one strobed result against the oldest expectation
  function void check_result(rwtd_pkg::out_res_t got);
    rwtd_pkg::out_res_t want;
    if (expected_results.size() == 0) begin
      $error("result with nothing expected: %p", got);
      mismatches++;
      return;
    end
    want = expected_results.pop_front();
    compare_field("started", want.started, got.started);
    compare_field("started_kind", want.started_kind, got.started_kind);
    compare_field("started_id", want.started_id, got.started_id);
    compare_field("status", want.status, got.status);
    compare_field("last", want.last, got.last);
  endfunction
endclass

module tb_readers_writer_task_dispatcher_unit;

  localparam int unsigned CYCLE_LIMIT   = 3_000_000;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned DRAIN_CYCLES  = 48;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  rwtd_pkg::in_req_t  in_req;
  logic               out_valid;
  rwtd_pkg::out_res_t out_res;

  dispatch_tracker tracker = new();
  int unsigned     items_sent;
  int unsigned     max_gap;
  int unsigned     cycle_count;

  readers_writer_task_dispatcher_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_res  (out_res)
  );

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // Result monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if ($isunknown(out_valid)) begin
        $error("out_valid: expected 0 or 1, actual %b", out_valid);
        tracker.mismatches++;
      end else if (out_valid) begin
        tracker.check_result(out_res);
      end
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout with %0d results still expected", tracker.expected_results.size());
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic logic [rwtd_pkg::ID_FIELD_W-1:0] rand_id();
    return rwtd_pkg::ID_FIELD_W'($urandom_range(0, 255));
  endfunction

  // Present one request after a gap, hold it until taken
  task automatic send_request(input logic [rwtd_pkg::CMD_W-1:0] cmd,
                              input logic [rwtd_pkg::ID_FIELD_W-1:0] id,
                              input int unsigned gap);
    rwtd_pkg::in_req_t req;
    rwtd_pkg::in_req_t junk;
    req.cmd      = cmd;
    req.task_id  = id;
    junk.cmd     = rwtd_pkg::CMD_W'($urandom_range(0, 3));
    junk.task_id = rand_id();
    @(negedge clk);
    if (gap > 0) begin
      start  <= 1'b0;
      in_req <= junk;
      repeat (gap) @(negedge clk);
    end
    start  <= 1'b1;
    in_req <= req;
    do @(posedge clk); while (busy);
    tracker.note_request(req);
  endtask

  task automatic send_cmd(input logic [rwtd_pkg::CMD_W-1:0] cmd,
                          input logic [rwtd_pkg::ID_FIELD_W-1:0] id);
    send_request(cmd, id, $urandom_range(0, max_gap));
    items_sent++;
  endtask

  // Finish every running and waiting task
  task automatic drain_tasks();
    while (tracker.active_reads > 0 || tracker.writes > 0)
      send_cmd(tracker.active_reads > 0 ? rwtd_pkg::CMD_RD_DONE : rwtd_pkg::CMD_WR_DONE,
               rand_id());
  endtask

  // Reads pile up behind writes, then get released together
  task automatic read_backlog_episode();
    int unsigned n_run;
    int unsigned n_wr;
    int unsigned n_rd;
    n_run = $urandom_range(0, 3);
    n_wr  = $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0)
      n_rd = $urandom_range(rwtd_pkg::RD_DEPTH - 2, rwtd_pkg::RD_DEPTH + 3);
    else
      n_rd = $urandom_range(1, 8);
    repeat (n_run) send_cmd(rwtd_pkg::CMD_RD_ENQ, rand_id());
    repeat (n_wr) send_cmd(rwtd_pkg::CMD_WR_ENQ, rand_id());
    repeat (n_rd) begin
      if ($urandom_range(0, 7) == 0)
        send_cmd($urandom_range(0, 1) ? rwtd_pkg::CMD_RD_DONE : rwtd_pkg::CMD_WR_DONE,
                 rand_id());
      send_cmd(rwtd_pkg::CMD_RD_ENQ, rand_id());
    end
    drain_tasks();
  endtask

  // Send WR_DEPTH to WR_DEPTH + 4 writes, so the write queue fills to near or past its depth
  task automatic write_backlog_episode();
    int unsigned n;
    n = $urandom_range(rwtd_pkg::WR_DEPTH - 1, rwtd_pkg::WR_DEPTH + 3);
    if ($urandom_range(0, 1)) send_cmd(rwtd_pkg::CMD_RD_ENQ, rand_id());
    repeat (n + 1) send_cmd(rwtd_pkg::CMD_WR_ENQ, rand_id());
    repeat ($urandom_range(0, 3)) send_cmd(rwtd_pkg::CMD_RD_ENQ, rand_id());
    drain_tasks();
  endtask

  // Mostly sensible next request given the current lock state, some noise
  task automatic mixed_item();
    int unsigned                pick;
    logic [rwtd_pkg::CMD_W-1:0] cmd;
    pick = $urandom_range(0, 99);
    if (pick < 10)
      cmd = rwtd_pkg::CMD_W'($urandom_range(0, 3));
    else if (tracker.writes > 0 && tracker.active_reads == 0)
      cmd = (pick < 55) ? rwtd_pkg::CMD_WR_DONE :
            (pick < 80) ? rwtd_pkg::CMD_RD_ENQ : rwtd_pkg::CMD_WR_ENQ;
    else if (tracker.active_reads > 0)
      cmd = (pick < 50) ? rwtd_pkg::CMD_RD_DONE :
            (pick < 80) ? rwtd_pkg::CMD_RD_ENQ : rwtd_pkg::CMD_WR_ENQ;
    else
      cmd = (pick < 65) ? rwtd_pkg::CMD_RD_ENQ : rwtd_pkg::CMD_WR_ENQ;
    send_cmd(cmd, rand_id());
  endtask

  initial begin
    rst_n   = 1'b0;
    start   = 1'b0;
    in_req  = '0;
    max_gap = 8;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: done events on an idle lock, start/queue/release paths, id extremes
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_WR_DONE, 8'hFF);
    send_cmd(rwtd_pkg::CMD_RD_ENQ, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_ENQ, 8'hFF);
    send_cmd(rwtd_pkg::CMD_WR_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_WR_ENQ, 8'hA5);
    send_cmd(rwtd_pkg::CMD_WR_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_ENQ, 8'h5A);
    send_cmd(rwtd_pkg::CMD_RD_ENQ, 8'h3C);
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'hFF);
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_ENQ, 8'h81);
    send_cmd(rwtd_pkg::CMD_WR_ENQ, 8'h01);
    send_cmd(rwtd_pkg::CMD_WR_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_WR_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_RD_DONE, 8'h00);
    send_cmd(rwtd_pkg::CMD_WR_ENQ, 8'hFF);
    send_cmd(rwtd_pkg::CMD_WR_DONE, 8'h00);
    drain_tasks();

    // Random episodes
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      max_gap = ($urandom_range(0, 3) == 0) ? 0 : 8;
      case ($urandom_range(0, 9))
        0, 1, 2: read_backlog_episode();
        3:       write_backlog_episode();
        default: repeat (8) mixed_item();
      endcase
    end
    drain_tasks();

    @(negedge clk);
    start <= 1'b0;

    // Wait out every owed result, then a little longer for strays
    while (tracker.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (tracker.mismatches == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

[files.f]
sv/rwtd_pkg.sv
sv/rwtd_ram.sv
sv/rwtd_ctrl.sv
sv/rwtd_dp.sv
sv/readers_writer_task_dispatcher_unit.sv
sv/rwtd_checker.sv
test/tb_readers_writer_task_dispatcher_unit.sv
